### hdl/srrw_pkg.sv
// shared types and constants of the selective-repeat receive window
// no dependencies; imported by every module of the block but srrw_ram

package srrw_pkg;

   // result codes
   typedef enum logic [2:0] {
      KIND_NEW  = 3'd0,
      KIND_DUP  = 3'd1,
      KIND_DROP = 3'd2,
      KIND_REL  = 3'd3,
      KIND_FIN  = 3'd4
   } result_kind_type;

   // one incoming segment header
   typedef struct packed {
      logic        fin_flag;
      logic        ack_flag;
      logic [31:0] seq_number;
      logic [15:0] payload_ref;
   } req_item_type;

   // one result transfer
   typedef struct packed {
      result_kind_type result_kind;
      logic [31:0]     number;
      logic [15:0]     released_ref;
      logic            last_result;
   } rsp_item_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEAD,
      ST_RELEASE,
      ST_STOPPED
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // take the request and update the window
      logic head;     // show the first result of the item
      logic step;     // show one released slot
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic more;     // released slots follow the first result
      logic fin;      // item was a fin, stop afterwards
      logic last;     // current released slot is the final one
   } dp_status_type;

endpackage

### hdl/srrw_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies

module srrw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/srrw_ctrl.sv
// controller of the receive window: sequences accept, first result and release
// depends on srrw_pkg

module srrw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output srrw_pkg::ctrl_cmd_type cmd,
   input  srrw_pkg::dp_status_type status
);

   import srrw_pkg::*;

   ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            busy     = 1'b1;
            cmd.head = 1'b1;
            if (status.more) begin
               state_in = ST_RELEASE;
            end else if (status.fin) begin
               state_in = ST_STOPPED;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RELEASE: begin
            busy     = 1'b1;
            cmd.step = 1'b1;
            if (status.last) begin
               state_in = status.fin ? ST_STOPPED : ST_IDLE;
            end
         end
         ST_STOPPED: begin
            // accepted segments are ignored until reset
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/srrw_datapath.sv
// datapath of the receive window: base, received bits, handle store, results
// depends on srrw_pkg and srrw_ram

module srrw_datapath #(
   parameter int WINDOW   = 32,
   parameter int SEQ_BITS = 32,
   parameter int REF_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  srrw_pkg::req_item_type  req_data,
   input  srrw_pkg::ctrl_cmd_type  cmd,
   output srrw_pkg::dp_status_type status,
   output logic                    rsp_valid,
   output srrw_pkg::rsp_item_type  rsp_data
);

   import srrw_pkg::*;

   localparam int IDX_BITS = $clog2(WINDOW);
   localparam int REF_KEEP = (REF_BITS < 16) ? REF_BITS : 16;

   logic [SEQ_BITS-1:0] base_ff, base_in;
   logic [WINDOW-1:0]   received_ff, received_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [IDX_BITS-1:0] idx_next;
   result_kind_type     kind_ff, kind_in;
   logic [31:0]         num_ff, num_in;
   logic                more_ff, more_in;
   logic                all_ff, all_in;
   logic                fin_ff, fin_in;

   logic [SEQ_BITS-1:0] seq;
   logic [SEQ_BITS:0]   wend;
   logic [SEQ_BITS-1:0] slot;
   logic [IDX_BITS-1:0] slot_idx;
   logic                is_fin, above, below, is_new, full;
   logic                step_last;
   logic [REF_KEEP-1:0] ram_q;
   logic [IDX_BITS-1:0] rd_addr;
   logic [SEQ_BITS-1:0] rel_seq;

   // classify the incoming segment against the window
   assign seq      = req_data.seq_number[SEQ_BITS-1:0];
   assign wend     = {1'b0, base_ff} + (SEQ_BITS+1)'(WINDOW - 1);
   assign slot     = seq - base_ff;
   assign slot_idx = slot[IDX_BITS-1:0];
   assign full     = &received_ff;
   assign is_fin   = req_data.fin_flag && !req_data.ack_flag;
   assign above    = {1'b0, seq} > wend;
   assign below    = seq < base_ff;
   assign is_new   = !is_fin && !above && !below && !received_ff[slot_idx];

   // release walk position
   assign idx_next  = idx_ff + IDX_BITS'(1);
   assign step_last = (idx_ff == IDX_BITS'(WINDOW - 1)) ||
                      (!all_ff && !received_ff[idx_next]);
   assign rd_addr   = cmd.head ? '0 : idx_next;
   assign rel_seq   = base_ff + SEQ_BITS'(idx_ff);

   // next state of the window and of the item registers
   always_comb begin
      base_in     = base_ff;
      received_in = received_ff;
      idx_in      = idx_ff;
      kind_in     = kind_ff;
      num_in      = num_ff;
      more_in     = more_ff;
      all_in      = all_ff;
      fin_in      = fin_ff;
      if (cmd.load) begin
         idx_in  = '0;
         num_in  = 32'(seq);
         fin_in  = is_fin;
         all_in  = 1'b0;
         more_in = 1'b0;
         if (is_fin) begin
            kind_in = KIND_FIN;
            more_in = received_ff[0];
         end else if (above) begin
            kind_in = KIND_DROP;
            more_in = full;
            all_in  = full;
         end else if (is_new) begin
            kind_in               = KIND_NEW;
            received_in[slot_idx] = 1'b1;
         end else begin
            kind_in = KIND_DUP;
         end
      end
      if (cmd.step) begin
         idx_in = idx_next;
         if (step_last && all_ff) begin
            received_in = '0;
            base_in     = base_ff + SEQ_BITS'(WINDOW);
         end
      end
   end

   // window state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= SEQ_BITS'(1);
         received_ff <= '0;
         more_ff     <= 1'b0;
         all_ff      <= 1'b0;
         fin_ff      <= 1'b0;
      end else begin
         base_ff     <= base_in;
         received_ff <= received_in;
         more_ff     <= more_in;
         all_ff      <= all_in;
         fin_ff      <= fin_in;
      end
   end

   // item payload registers
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      kind_ff <= kind_in;
      num_ff  <= num_in;
   end

   // payload handle store
   srrw_ram #(
      .WIDTH (REF_KEEP),
      .DEPTH (WINDOW)
   ) u_refs (
      .clock   (clock),
      .wr_en   (cmd.load && is_new),
      .wr_addr (slot_idx),
      .wr_data (req_data.payload_ref[REF_KEEP-1:0]),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // result transfer
   always_comb begin
      rsp_valid             = cmd.head || cmd.step;
      rsp_data.result_kind  = kind_ff;
      rsp_data.number       = num_ff;
      rsp_data.released_ref = '0;
      rsp_data.last_result  = !more_ff;
      if (cmd.step) begin
         rsp_data.result_kind  = KIND_REL;
         rsp_data.number       = 32'(rel_seq);
         rsp_data.released_ref = 16'(ram_q);
         rsp_data.last_result  = step_last;
      end
   end

   // status for the controller
   assign status.more = more_ff;
   assign status.fin  = fin_ff;
   assign status.last = step_last;

endmodule

### hdl/selective_repeat_receive_window_unit.sv
// top level of the selective-repeat receive window
// depends on srrw_pkg, srrw_ctrl, srrw_datapath
//
// Usage: a segment header is transferred on req_data at a rising edge where
// start is high and busy is low. Each result appears on rsp_data for exactly
// one cycle with rsp_valid high; the receiver always takes it and cannot
// stall the block. last_result marks the final result of a segment.
// The first result of a segment shows in the cycle after the transfer; an
// ordinary ack, duplicate or drop gives only that result. A full-window
// flush releases all WINDOW slots after it, a fin releases each consecutively
// received slot from the base; the walk is one slot per cycle, set by the
// single read port of the handle memory.
// busy is high while results are being produced.
// Reset (synchronous, active high): base is 1, no slot is received. After a
// fin the block keeps taking segments but ignores them until reset.

module selective_repeat_receive_window_unit #(
   parameter int WINDOW   = 32,
   parameter int SEQ_BITS = 32,
   parameter int REF_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  srrw_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   output srrw_pkg::rsp_item_type rsp_data
);

   import srrw_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencing
   srrw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // window state and results
   srrw_datapath #(
      .WINDOW   (WINDOW),
      .SEQ_BITS (SEQ_BITS),
      .REF_BITS (REF_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### test/srrw_window_checker.sv
// result checker for the selective-repeat receive window testbench
// depends on srrw_pkg; watches the segment and result transfers of the unit

module srrw_window_checker #(
   parameter int WINDOW = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  srrw_pkg::req_item_type req_data,
   input  logic                   rsp_valid,
   input  srrw_pkg::rsp_item_type rsp_data,
   output int                     fail_count,
   output int                     outstanding
);

   import srrw_pkg::*;

   // predicted window state
   logic [31:0] base_seq;
   logic        slot_taken [WINDOW];
   logic [15:0] slot_handle [WINDOW];
   logic        rx_stopped;

   // results still to come, oldest first
   rsp_item_type due_results [$];
   rsp_item_type seen;
   rsp_item_type want;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic void queue_result(result_kind_type kind, logic [31:0] num,
                                        logic [15:0] handle);
      rsp_item_type r;
      r.result_kind  = kind;
      r.number       = num;
      r.released_ref = handle;
      r.last_result  = 1'b0;
      due_results.push_back(r);
   endfunction

   // work out the results of one accepted segment and update the window
   function automatic void apply_segment(req_item_type seg);
      logic [32:0]  win_end;
      logic [31:0]  offset;
      bit           all_in;
      rsp_item_type tail;
      if (rx_stopped)
         return;
      win_end = {1'b0, base_seq} + 33'(WINDOW - 1);
      if (seg.fin_flag && !seg.ack_flag) begin
         // fin: ack it, release the run of received slots from the base, stop
         rx_stopped = 1'b1;
         queue_result(KIND_FIN, seg.seq_number, 16'd0);
         for (int i = 0; i < WINDOW && slot_taken[i]; i++)
            queue_result(KIND_REL, base_seq + 32'(i), slot_handle[i]);
      end else if ({1'b0, seg.seq_number} > win_end) begin
         // above the window: drop, and flush if every slot is in
         queue_result(KIND_DROP, seg.seq_number, 16'd0);
         all_in = 1'b1;
         for (int i = 0; i < WINDOW; i++)
            if (!slot_taken[i])
               all_in = 1'b0;
         if (all_in) begin
            for (int i = 0; i < WINDOW; i++) begin
               queue_result(KIND_REL, base_seq + 32'(i), slot_handle[i]);
               slot_taken[i] = 1'b0;
            end
            base_seq = base_seq + 32'(WINDOW);
         end
      end else if (seg.seq_number < base_seq) begin
         // below the window
         queue_result(KIND_DUP, seg.seq_number, 16'd0);
      end else begin
         offset = seg.seq_number - base_seq;
         if (!slot_taken[offset]) begin
            slot_taken[offset]  = 1'b1;
            slot_handle[offset] = seg.payload_ref;
            queue_result(KIND_NEW, seg.seq_number, 16'd0);
         end else begin
            queue_result(KIND_DUP, seg.seq_number, 16'd0);
         end
      end
      // flag the final result of this segment
      tail = due_results.pop_back();
      tail.last_result = 1'b1;
      due_results.push_back(tail);
   endfunction

   // results first, then the segment taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         base_seq   = 32'd1;
         rx_stopped = 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            slot_taken[i]  = 1'b0;
            slot_handle[i] = 16'd0;
         end
         due_results.delete();
      end else begin
         if (rsp_valid) begin
            seen = rsp_data;
            if (due_results.size() == 0) begin
               $error("unexpected result: kind %0d number %h ref %h last %b",
                      seen.result_kind, seen.number, seen.released_ref,
                      seen.last_result);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (seen.result_kind !== want.result_kind) begin
                  $error("result_kind: expected %0d, got %0d",
                         want.result_kind, seen.result_kind);
                  fail_count++;
               end
               if (seen.number !== want.number) begin
                  $error("number: expected %h, got %h", want.number, seen.number);
                  fail_count++;
               end
               if (seen.released_ref !== want.released_ref) begin
                  $error("released_ref: expected %h, got %h",
                         want.released_ref, seen.released_ref);
                  fail_count++;
               end
               if (seen.last_result !== want.last_result) begin
                  $error("last_result: expected %b, got %b",
                         want.last_result, seen.last_result);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            apply_segment(req_data);
      end
      outstanding = due_results.size();
   end

endmodule

### test/selective_repeat_receive_window_unit_test.sv
// testbench top of the selective-repeat receive window unit
// depends on srrw_pkg, the unit and srrw_window_checker; drives segments only

module selective_repeat_receive_window_unit_test;
   import srrw_pkg::*;

   localparam int WINDOW    = 32;
   localparam int MAX_CYCLE = 200000;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_data;
   logic         rsp_valid;
   rsp_item_type rsp_data;
   int           fail_count;
   int           outstanding;
   int           cycle_count;

   // stimulus view of the window, used only to shape segment sequences
   logic [31:0]  win_base;
   logic [31:0]  filled;
   bit           calm;

   selective_repeat_receive_window_unit #(
      .WINDOW(WINDOW)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   srrw_window_checker #(
      .WINDOW(WINDOW)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .outstanding(outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLE) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // one segment transfer; entered and left at a falling edge
   task automatic send_segment(input logic fin, input logic ack, input logic [31:0] seq,
                               input logic [15:0] handle);
      req_item_type seg;
      logic [4:0]   offset;
      seg.fin_flag    = fin;
      seg.ack_flag    = ack;
      seg.seq_number  = seq;
      seg.payload_ref = handle;
      if (!calm && $urandom_range(99) < 14) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= seg;
      do @(posedge clock); while (busy);
      @(negedge clock);
      // follow the window so rounds can be built
      if (!(fin && !ack)) begin
         if ({1'b0, seq} > {1'b0, win_base} + 33'(WINDOW - 1)) begin
            if (&filled) begin
               win_base = win_base + 32'(WINDOW);
               filled   = '0;
            end
         end else if (seq >= win_base) begin
            offset         = 5'(seq - win_base);
            filled[offset] = 1'b1;
         end
      end
   endtask

   // hold the sender off until every result has come
   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
   endtask

   // a stray segment: repeat, below the window, a random number, or fin with ack
   task automatic send_noise();
      int pick;
      int k;
      pick = $urandom_range(3);
      k    = $urandom_range(WINDOW - 1);
      case (pick)
         0: begin
            if (filled[k])
               send_segment(1'b0, 1'($urandom_range(1)), win_base + 32'(k),
                            16'($urandom));
            else
               send_segment(1'b0, 1'($urandom_range(1)),
                            $urandom_range(win_base - 1, 0), 16'($urandom));
         end
         1: send_segment(1'b0, 1'($urandom_range(1)), $urandom_range(win_base - 1, 0),
                         16'($urandom));
         2: send_segment(1'b0, 1'($urandom_range(1)), $urandom, 16'($urandom));
         default: send_segment(1'b1, 1'b1, $urandom, 16'($urandom));
      endcase
   endtask

   // fill the open slots in random order with some noise in between
   task automatic fill_window();
      int order [WINDOW];
      int j;
      int tmp;
      logic fin;
      for (int i = 0; i < WINDOW; i++)
         order[i] = i;
      for (int i = WINDOW - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < WINDOW; i++) begin
         if ($urandom_range(99) < 15)
            send_noise();
         if (!filled[order[i]]) begin
            fin = 1'($urandom_range(1));
            send_segment(fin, fin ? 1'b1 : 1'($urandom_range(1)),
                         win_base + 32'(order[i]), 16'($urandom));
         end
      end
   endtask

   // stimulus
   initial begin
      int run_len;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      win_base = 32'd1;
      filled   = '0;
      calm     = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero sequence, window edges, repeats, drops, fin with ack
      send_segment(1'b0, 1'b0, 32'd0, 16'h1234);
      send_segment(1'b0, 1'b0, 32'd1, 16'hFFFF);
      send_segment(1'b0, 1'b0, 32'd1, 16'h0000);
      send_segment(1'b0, 1'b1, 32'd32, 16'h0000);
      send_segment(1'b0, 1'b0, 32'd33, 16'hFFFF);
      send_segment(1'b0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF);
      send_segment(1'b0, 1'b1, 32'h8000_0000, 16'h0001);
      send_segment(1'b1, 1'b1, 32'd2, 16'hA5A5);
      send_segment(1'b1, 1'b1, 32'd2, 16'h5A5A);
      send_segment(1'b0, 1'b1, 32'd3, 16'h5A5A);
      send_segment(1'b1, 1'b1, 32'hFFFF_FFFE, 16'h8000);
      send_segment(1'b0, 1'b0, 32'd16, 16'h8001);

      // full windows, each closed by a drop that flushes it
      for (int round = 0; round < 3; round++) begin
         calm = (round == 1);
         fill_window();
         if (round == 0)
            drain_results();
         if ($urandom_range(1))
            send_segment(1'b0, 1'($urandom_range(1)),
                         win_base + 32'(WINDOW) + $urandom_range(1000), 16'($urandom));
         else
            send_segment(1'b0, 1'($urandom_range(1)), 32'h8000_0000 | $urandom,
                         16'($urandom));
         // behind the advanced window
         if (round == 0) begin
            send_segment(1'b0, 1'b0, win_base - 32'd1, 16'($urandom));
            send_segment(1'b0, 1'b1, win_base - 32'(WINDOW), 16'($urandom));
         end
      end
      calm = 1'b0;

      // partial window: a run from the base, a gap, some slots beyond
      run_len = $urandom_range(12, 3);
      for (int i = 0; i < run_len; i++)
         send_segment(1'b0, 1'($urandom_range(1)), win_base + 32'(i), 16'($urandom));
      for (int i = 0; i < 3; i++)
         send_segment(1'b0, 1'b0, win_base + 32'($urandom_range(WINDOW - 1, run_len + 1)),
                      16'($urandom));

      // fin ends the stream; later segments are ignored
      send_segment(1'b1, 1'b0, $urandom, 16'($urandom));
      repeat (4)
         send_segment(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                      16'($urandom));

      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
      repeat (3 * WINDOW) @(posedge clock);

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### sim.f
hdl/srrw_pkg.sv
hdl/srrw_ram.sv
hdl/srrw_ctrl.sv
hdl/srrw_datapath.sv
hdl/selective_repeat_receive_window_unit.sv
test/srrw_window_checker.sv
test/selective_repeat_receive_window_unit_test.sv
